// ===== hdl/gss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the golden-section minimum search block.
// Used by gss_ctrl, gss_dpath, the top level and gss_checker; no dependencies.

package gss_pkg;

   // result kinds on the rsp channel
   localparam logic [1:0] RK_EVAL    = 2'd0;
   localparam logic [1:0] RK_MINIMUM = 2'd1;
   localparam logic [1:0] RK_ERROR   = 2'd2;

   // transaction kinds on the req channel
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   localparam int TOL_W = 31;

   // 1/phi in Q30
   localparam int               INV_PHI_W   = 30;
   localparam logic [29:0]      INV_PHI_Q30 = 30'd663608942;
   localparam int               SPLIT_BITS  = 16;
   localparam int               ROUND_SHIFT = 14;
   localparam int               ROUND_BIT   = 13;

   typedef enum logic [1:0] {
      RES_ERROR  = 2'd0,
      RES_LO_END = 2'd1,
      RES_HI_END = 2'd2,
      RES_FINAL  = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic        load_start;
      logic        store_left;
      logic        store_right;
      logic        store_end_low;
      logic        narrow;
      logic        calc_diff;
      logic        mul_lo;
      logic        mul_hi;
      logic        calc_step;
      logic        calc_probe;
      logic        probe_right;
      logic        res_load;
      res_sel_type res_sel;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic wide;
      logic left_ge_right;
   } status_type;

endpackage

// ===== hdl/gss_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: interval ends, probes and their values, the shared 1/phi multiplier,
// saturation, tolerance register and the rsp payload register. Depends on gss_pkg.

module gss_dpath #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gss_pkg::cmd_type                    cmd,
   output gss_pkg::status_type                 status,
   input  logic                                csr_wr_en,
   input  logic [gss_pkg::TOL_W-1:0]           csr_wr_data,
   input  logic signed [DATA_WIDTH-1:0]        req_interval_low,
   input  logic signed [DATA_WIDTH-1:0]        req_interval_high,
   input  logic signed [DATA_WIDTH-1:0]        req_func_value,
   output logic [1:0]                          rsp_result_kind,
   output logic signed [DATA_WIDTH-1:0]        rsp_point
);

   localparam int DW        = DATA_WIDTH;
   localparam int MAG_W     = DW + 1;
   localparam int EXT_W     = DW + 2;
   localparam int HI_W      = MAG_W - gss_pkg::SPLIT_BITS;
   localparam int MUL_A_W   = (HI_W > gss_pkg::SPLIT_BITS) ? HI_W : gss_pkg::SPLIT_BITS;
   localparam int PROD_W    = MUL_A_W + gss_pkg::INV_PHI_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int CMP_W     = (MAG_W > gss_pkg::TOL_W) ? MAG_W : gss_pkg::TOL_W;
   localparam int TOL_RESET = ((1 << FRAC_BITS) + 500) / 1000;

   logic signed [DW-1:0]    lo_end_ff, lo_end_in;
   logic signed [DW-1:0]    hi_end_ff, hi_end_in;
   logic signed [DW-1:0]    probe_left_ff, probe_left_in;
   logic signed [DW-1:0]    probe_right_ff, probe_right_in;
   logic signed [DW-1:0]    value_left_ff, value_left_in;
   logic signed [DW-1:0]    value_right_ff, value_right_in;
   logic signed [DW-1:0]    end_value_low_ff, end_value_low_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [gss_pkg::INV_PHI_W-1:0] lo_term_ff, lo_term_in;
   logic [PROD_W-1:0]       hi_prod_ff, hi_prod_in;
   logic signed [EXT_W-1:0] step_ff, step_in;
   logic [1:0]              res_kind_ff, res_kind_in;
   logic signed [DW-1:0]    res_point_ff, res_point_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic signed [DW-1:0]    rsp_point_ff, rsp_point_in;
   logic [gss_pkg::TOL_W-1:0] tolerance_ff, tolerance_in;

   logic signed [DW:0]      diff;
   logic [MUL_A_W-1:0]      mul_a;
   logic [PROD_W-1:0]       mul_p;
   logic [SUM_W-1:0]        round_sum;
   logic [MAG_W-1:0]        q_mag;
   logic signed [EXT_W-1:0] q_ext;
   logic signed [EXT_W-1:0] probe_raw;
   logic signed [DW-1:0]    probe_sat;
   logic                    probe_fits;
   logic signed [DW:0]      end_sum;
   logic signed [DW-1:0]    final_point;
   logic [gss_pkg::TOL_W-1:0] tol_eff;

   // interval width and its magnitude
   assign diff = (DW + 1)'(hi_end_ff) - (DW + 1)'(lo_end_ff);

   // shared multiplier by 1/phi: low 16 bits of the magnitude, then the rest
   assign mul_a = cmd.mul_hi ? MUL_A_W'(mag_ff[MAG_W-1:gss_pkg::SPLIT_BITS])
                             : MUL_A_W'(mag_ff[gss_pkg::SPLIT_BITS-1:0]);
   assign mul_p = PROD_W'(mul_a) * PROD_W'(gss_pkg::INV_PHI_Q30);

   assign round_sum = SUM_W'(hi_prod_ff) + (SUM_W'(1) << gss_pkg::ROUND_BIT)
                      + SUM_W'(lo_term_ff);
   assign q_mag     = MAG_W'(round_sum >> gss_pkg::ROUND_SHIFT);
   assign q_ext     = $signed({1'b0, q_mag});

   // probe with saturation to the data range
   assign probe_raw  = cmd.probe_right ? (EXT_W'(lo_end_ff) + step_ff)
                                       : (EXT_W'(hi_end_ff) - step_ff);
   assign probe_fits = (&probe_raw[EXT_W-1:DW-1]) | ~(|probe_raw[EXT_W-1:DW-1]);
   assign probe_sat  = probe_fits ? probe_raw[DW-1:0]
                     : (probe_raw[EXT_W-1] ? $signed({1'b1, {(DW-1){1'b0}}})
                                           : $signed({1'b0, {(DW-1){1'b1}}}));

   // final pick: the end with the smaller value, or floor midpoint on a tie
   assign end_sum = (DW + 1)'(lo_end_ff) + (DW + 1)'(hi_end_ff);
   always_comb begin
      if (end_value_low_ff < req_func_value) begin
         final_point = lo_end_ff;
      end else if (end_value_low_ff > req_func_value) begin
         final_point = hi_end_ff;
      end else begin
         final_point = end_sum[DW:1];
      end
   end

   assign tol_eff = (tolerance_ff == '0) ? gss_pkg::TOL_W'(1) : tolerance_ff;

   assign status.wide          = CMP_W'(mag_ff) > CMP_W'(tol_eff);
   assign status.left_ge_right = value_left_ff >= value_right_ff;

   always_comb begin
      lo_end_in        = lo_end_ff;
      hi_end_in        = hi_end_ff;
      probe_left_in    = probe_left_ff;
      probe_right_in   = probe_right_ff;
      value_left_in    = value_left_ff;
      value_right_in   = value_right_ff;
      end_value_low_in = end_value_low_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      lo_term_in       = lo_term_ff;
      hi_prod_in       = hi_prod_ff;
      step_in          = step_ff;
      res_kind_in      = res_kind_ff;
      res_point_in     = res_point_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_point_in     = rsp_point_ff;
      tolerance_in     = csr_wr_en ? csr_wr_data : tolerance_ff;

      if (cmd.load_start) begin
         lo_end_in = req_interval_low;
         hi_end_in = req_interval_high;
      end
      if (cmd.store_left) begin
         value_left_in = req_func_value;
      end
      if (cmd.store_right) begin
         value_right_in = req_func_value;
      end
      if (cmd.store_end_low) begin
         end_value_low_in = req_func_value;
      end
      if (cmd.narrow) begin
         if (status.left_ge_right) begin
            lo_end_in     = probe_left_ff;
            probe_left_in = probe_right_ff;
            value_left_in = value_right_ff;
         end else begin
            hi_end_in      = probe_right_ff;
            probe_right_in = probe_left_ff;
            value_right_in = value_left_ff;
         end
      end
      if (cmd.calc_diff) begin
         neg_in = diff[DW];
         mag_in = diff[DW] ? $unsigned(-diff) : $unsigned(diff);
      end
      if (cmd.mul_lo) begin
         lo_term_in = mul_p[gss_pkg::SPLIT_BITS +: gss_pkg::INV_PHI_W];
      end
      if (cmd.mul_hi) begin
         hi_prod_in = mul_p;
      end
      if (cmd.calc_step) begin
         step_in = neg_ff ? -q_ext : q_ext;
      end
      if (cmd.calc_probe) begin
         res_kind_in  = gss_pkg::RK_EVAL;
         res_point_in = probe_sat;
         if (cmd.probe_right) begin
            probe_right_in = probe_sat;
         end else begin
            probe_left_in = probe_sat;
         end
      end
      if (cmd.res_load) begin
         unique case (cmd.res_sel)
            gss_pkg::RES_ERROR: begin
               res_kind_in  = gss_pkg::RK_ERROR;
               res_point_in = '0;
            end
            gss_pkg::RES_LO_END: begin
               res_kind_in  = gss_pkg::RK_EVAL;
               res_point_in = lo_end_ff;
            end
            gss_pkg::RES_HI_END: begin
               res_kind_in  = gss_pkg::RK_EVAL;
               res_point_in = hi_end_ff;
            end
            gss_pkg::RES_FINAL: begin
               res_kind_in  = gss_pkg::RK_MINIMUM;
               res_point_in = final_point;
            end
            default: begin
               res_kind_in  = gss_pkg::RK_ERROR;
               res_point_in = '0;
            end
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_kind_in  = res_kind_ff;
         rsp_point_in = res_point_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_end_ff        <= lo_end_in;
      hi_end_ff        <= hi_end_in;
      probe_left_ff    <= probe_left_in;
      probe_right_ff   <= probe_right_in;
      value_left_ff    <= value_left_in;
      value_right_ff   <= value_right_in;
      end_value_low_ff <= end_value_low_in;
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      lo_term_ff       <= lo_term_in;
      hi_prod_ff       <= hi_prod_in;
      step_ff          <= step_in;
      res_kind_ff      <= res_kind_in;
      res_point_ff     <= res_point_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_point_ff     <= rsp_point_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= gss_pkg::TOL_W'(TOL_RESET);
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_point       = rsp_point_ff;

endmodule

// ===== hdl/gss_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: search phase, probe-known flags, compute sequencer and rsp valid.
// Drives gss_dpath through gss_pkg::cmd_type; depends on gss_pkg.

module gss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  gss_pkg::status_type status,
   output gss_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      SQ_READY  = 8'b0000_0001,
      SQ_NARROW = 8'b0000_0010,
      SQ_DIFF   = 8'b0000_0100,
      SQ_MUL_LO = 8'b0000_1000,
      SQ_MUL_HI = 8'b0001_0000,
      SQ_STEP   = 8'b0010_0000,
      SQ_PROBE  = 8'b0100_0000,
      SQ_EMIT   = 8'b1000_0000
   } seq_type;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b0_0001,
      PH_LEFT   = 5'b0_0010,
      PH_RIGHT  = 5'b0_0100,
      PH_END_LO = 5'b0_1000,
      PH_END_HI = 5'b1_0000
   } phase_type;

   seq_type   seq_ff, seq_in;
   phase_type phase_ff, phase_in;
   logic      left_known_ff, left_known_in;
   logic      right_known_ff, right_known_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (seq_ff == SQ_READY);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      seq_in         = seq_ff;
      phase_in       = phase_ff;
      left_known_in  = left_known_ff;
      right_known_in = right_known_ff;
      cmd            = '0;
      cmd.res_sel    = gss_pkg::RES_ERROR;

      unique case (seq_ff)
         SQ_READY: begin
            if (accept) begin
               if (req_kind == gss_pkg::KIND_START) begin
                  if (phase_ff == PH_IDLE) begin
                     cmd.load_start = 1'b1;
                     left_known_in  = 1'b0;
                     right_known_in = 1'b0;
                     seq_in         = SQ_DIFF;
                  end else begin
                     // start while busy: report and keep the running search
                     cmd.res_load = 1'b1;
                     cmd.res_sel  = gss_pkg::RES_ERROR;
                     seq_in       = SQ_EMIT;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_LEFT: begin
                        cmd.store_left = 1'b1;
                        left_known_in  = 1'b1;
                        seq_in         = right_known_ff ? SQ_NARROW : SQ_DIFF;
                     end
                     PH_RIGHT: begin
                        cmd.store_right = 1'b1;
                        right_known_in  = 1'b1;
                        seq_in          = left_known_ff ? SQ_NARROW : SQ_DIFF;
                     end
                     PH_END_LO: begin
                        cmd.store_end_low = 1'b1;
                        cmd.res_load      = 1'b1;
                        cmd.res_sel       = gss_pkg::RES_HI_END;
                        phase_in          = PH_END_HI;
                        seq_in            = SQ_EMIT;
                     end
                     PH_END_HI: begin
                        cmd.res_load   = 1'b1;
                        cmd.res_sel    = gss_pkg::RES_FINAL;
                        phase_in       = PH_IDLE;
                        left_known_in  = 1'b0;
                        right_known_in = 1'b0;
                        seq_in         = SQ_EMIT;
                     end
                     default: begin
                        // reply while idle
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = gss_pkg::RES_ERROR;
                        phase_in     = PH_IDLE;
                        seq_in       = SQ_EMIT;
                     end
                  endcase
               end
            end
         end
         SQ_NARROW: begin
            cmd.narrow     = 1'b1;
            left_known_in  = status.left_ge_right;
            right_known_in = ~status.left_ge_right;
            seq_in         = SQ_DIFF;
         end
         SQ_DIFF: begin
            cmd.calc_diff = 1'b1;
            seq_in        = SQ_MUL_LO;
         end
         SQ_MUL_LO: begin
            if (status.wide) begin
               cmd.mul_lo = 1'b1;
               seq_in     = SQ_MUL_HI;
            end else begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = gss_pkg::RES_LO_END;
               phase_in     = PH_END_LO;
               seq_in       = SQ_EMIT;
            end
         end
         SQ_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            seq_in     = SQ_STEP;
         end
         SQ_STEP: begin
            cmd.calc_step = 1'b1;
            seq_in        = SQ_PROBE;
         end
         SQ_PROBE: begin
            cmd.calc_probe  = 1'b1;
            cmd.probe_right = left_known_ff;
            phase_in        = left_known_ff ? PH_RIGHT : PH_LEFT;
            seq_in          = SQ_EMIT;
         end
         SQ_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               seq_in       = SQ_READY;
            end
         end
         default: begin
            seq_in = SQ_READY;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= SQ_READY;
         phase_ff       <= PH_IDLE;
         left_known_ff  <= 1'b0;
         right_known_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seq_ff         <= seq_in;
         phase_ff       <= phase_in;
         left_known_ff  <= left_known_in;
         right_known_ff <= right_known_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/golden_section_minimum_search_top.sv =====
`timescale 1ns / 1ps
// Golden-section minimum search, top level: joins gss_ctrl and gss_dpath.
// Depends on gss_pkg, gss_ctrl and gss_dpath.
//
// Usage:
//   req channel (valid/ready): a start transaction (req_kind = 0) carries an
//   interval; each reply transaction (req_kind = 1) carries f() at the point
//   the block last asked for. Every transaction yields exactly one rsp
//   transaction: an evaluate request (kind 0), the minimum found (kind 1),
//   or a protocol error (kind 2, point 0) for a start while a search runs or
//   a reply while idle. Errors leave the running search untouched.
//   csr port: csr_wr_en writes csr_wr_data into the tolerance register at
//   once; write it only while the block is idle.
//   From accept to rsp_valid: errors and end-point requests load the result
//   register, then rsp; other requests have the width checked against the
//   tolerance and, if it is wider, compute step and probe, and a reply that
//   completes a pair narrows the interval first. The 1/phi product runs
//   through one shared multiplier in two passes (low 16 bits, then the rest).
//   One transaction is in flight at a time; req_ready returns as rsp is loaded.
//   rsp holds in a register: a stalled receiver keeps rsp_valid and the
//   payload stable, and the block holds its next result until it drains.
//   Reset (synchronous, active high) returns to idle with tolerance 66 at
//   the default FRAC_BITS and drops any pending result.

module golden_section_minimum_search_top #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [DATA_WIDTH-1:0]  req_interval_low,
   input  logic signed [DATA_WIDTH-1:0]  req_interval_high,
   input  logic signed [DATA_WIDTH-1:0]  req_func_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_result_kind,
   output logic signed [DATA_WIDTH-1:0]  rsp_point,
   input  logic                          csr_wr_en,
   input  logic [gss_pkg::TOL_W-1:0]     csr_wr_data
);

   gss_pkg::cmd_type    cmd;
   gss_pkg::status_type status;

   // sequencing, phase tracking and the rsp valid flag
   gss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // interval, probes, arithmetic, tolerance and rsp payload
   gss_dpath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .req_func_value    (req_func_value),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_point         (rsp_point)
   );

endmodule

// ===== hdl/gss_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the golden-section search top level, and its bind.
// Depends on gss_pkg and golden_section_minimum_search_top.

module gss_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_result_kind,
   input logic signed [DATA_WIDTH-1:0] rsp_point
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point)
                                  && $stable(rsp_result_kind))
      else $error("stalled rsp transaction changed");

   // only defined result kinds leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_kind == gss_pkg::RK_EVAL
                    || rsp_result_kind == gss_pkg::RK_MINIMUM
                    || rsp_result_kind == gss_pkg::RK_ERROR)
      else $error("undefined result kind");

   // error results carry a zero point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == gss_pkg::RK_ERROR |-> rsp_point == '0)
      else $error("error result with nonzero point");

   // one transaction in flight: ready drops after each accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted twice in a row");

endmodule

bind golden_section_minimum_search_top gss_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_point       (rsp_point)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for golden_section_minimum_search_top: a scoreboard predicts every result.
// Stimulus answers each evaluate request from a test curve and adds protocol noise.
// Depends on gss_pkg and the top level.

module tb;

   localparam int DW           = 32;
   localparam int SETTLE       = 12;    // beyond the worst accept-to-rsp latency
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   // Longest legitimate quiet stretch is the hold-off plus one latency.
   // Allow several times that before declaring a hang.
   localparam int QUIET_LIMIT  = 3000;
   localparam int ITEMS_TARGET = 880;
   // 0.618034 in Q30, the golden ratio reciprocal
   localparam longint unsigned GOLDEN_Q30 = 64'd663608942;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] point;
   } gss_result_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_WAIT_A, ST_WAIT_B, ST_WAIT_LOW, ST_WAIT_HIGH
   } search_stage_type;

   typedef enum logic [2:0] {
      CV_BOWL, CV_VEE, CV_FLAT, CV_SLOPE, CV_NOISE
   } curve_type;

   typedef enum logic [1:0] {
      RX_OPEN, RX_COIN, RX_SLOW, RX_BEAT
   } rx_mode_type;

   // DUT ports; every input starts at a known value
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_kind = 1'b0;
   logic signed [DW-1:0]        req_interval_low = '0;
   logic signed [DW-1:0]        req_interval_high = '0;
   logic signed [DW-1:0]        req_func_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_result_kind;
   logic signed [DW-1:0]        rsp_point;
   logic                        csr_wr_en = 1'b0;
   logic [gss_pkg::TOL_W-1:0]   csr_wr_data = '0;

   // predicted block state
   longint unsigned  gs_tol = 64'd66;
   longint           gs_low, gs_high, gs_probe_a, gs_probe_b;
   longint           gs_fa, gs_fb, gs_f_low_end;
   bit               gs_a_known, gs_b_known;
   search_stage_type gs_stage = ST_IDLE;
   longint           gs_last_point;

   // results predicted but not yet seen on rsp
   gss_result_type   pending_results[$];

   // curve that answers evaluate requests
   curve_type        cur_shape;
   longint           cur_center, cur_offset;
   bit               cur_rising;

   int               mismatches = 0;
   int               sent_items = 0;
   int               burst_left = 0;
   int               quiet_cycles = 0;
   int               hold_seq = 0;
   int               hold_seen = 0;
   int               hold_left = 0;
   int               mode_left = 0;
   int               beat = 0;
   rx_mode_type      rx_mode = RX_OPEN;

   golden_section_minimum_search_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_interval_low  (req_interval_low),
      .req_interval_high (req_interval_high),
      .req_func_value    (req_func_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_point         (rsp_point),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic longint clip_word(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // Width times 1/phi: round the magnitude half up, then restore the sign.
   function automatic longint golden_fraction(longint d);
      longint unsigned mag, q;
      mag = (d < 0) ? -d : d;
      q = ((mag >> 16) * GOLDEN_Q30 + (64'd1 << 13)
           + (((mag & 64'hFFFF) * GOLDEN_Q30) >> 16)) >> 14;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Ask for the missing probe, or for f(low end) once the interval is narrow.
   function automatic gss_result_type ask_next();
      gss_result_type  r;
      longint          d, s;
      longint unsigned mag, tol;
      d   = gs_high - gs_low;
      mag = (d < 0) ? -d : d;
      tol = (gs_tol == 0) ? 64'd1 : gs_tol;
      r.kind = gss_pkg::RK_EVAL;
      if (mag > tol) begin
         s = golden_fraction(d);
         if (!gs_a_known) begin
            gs_probe_a = clip_word(gs_high - s);
            gs_stage   = ST_WAIT_A;
            r.point    = gs_probe_a[31:0];
         end else begin
            gs_probe_b = clip_word(gs_low + s);
            gs_stage   = ST_WAIT_B;
            r.point    = gs_probe_b[31:0];
         end
      end else begin
         gs_stage = ST_WAIT_LOW;
         r.point  = gs_low[31:0];
      end
      return r;
   endfunction

   // Drop the side with the larger value (the left side on a tie); the surviving probe keeps its value.
   function automatic void shrink_interval();
      if (gs_fa >= gs_fb) begin
         gs_low     = gs_probe_a;
         gs_probe_a = gs_probe_b;
         gs_fa      = gs_fb;
         gs_a_known = 1'b1;
         gs_b_known = 1'b0;
      end else begin
         gs_high    = gs_probe_b;
         gs_probe_b = gs_probe_a;
         gs_fb      = gs_fa;
         gs_b_known = 1'b1;
         gs_a_known = 1'b0;
      end
   endfunction

   function automatic gss_result_type predict_search(logic kind, longint lo, longint hi,
                                                     longint fv);
      gss_result_type r;
      longint         c;
      r.kind  = gss_pkg::RK_ERROR;
      r.point = '0;
      if (kind == gss_pkg::KIND_START) begin
         // a start while a search runs is refused and changes nothing
         if (gs_stage == ST_IDLE) begin
            gs_low     = lo;
            gs_high    = hi;
            gs_a_known = 1'b0;
            gs_b_known = 1'b0;
            r = ask_next();
         end
      end else begin
         case (gs_stage)
            ST_WAIT_A: begin
               gs_fa      = fv;
               gs_a_known = 1'b1;
               if (gs_b_known) shrink_interval();
               r = ask_next();
            end
            ST_WAIT_B: begin
               gs_fb      = fv;
               gs_b_known = 1'b1;
               if (gs_a_known) shrink_interval();
               r = ask_next();
            end
            ST_WAIT_LOW: begin
               gs_f_low_end = fv;
               gs_stage     = ST_WAIT_HIGH;
               r.kind       = gss_pkg::RK_EVAL;
               r.point      = gs_high[31:0];
            end
            ST_WAIT_HIGH: begin
               if (gs_f_low_end < fv) c = gs_low;
               else if (gs_f_low_end > fv) c = gs_high;
               else c = (gs_low + gs_high) >>> 1;   // tie: midpoint, floored
               gs_stage   = ST_IDLE;
               gs_a_known = 1'b0;
               gs_b_known = 1'b0;
               r.kind     = gss_pkg::RK_MINIMUM;
               r.point    = c[31:0];
            end
            default: gs_stage = ST_IDLE;   // reply while idle
         endcase
      end
      // keep the point the block is waiting on; errors leave it alone
      if (r.kind == gss_pkg::RK_EVAL) gs_last_point = longint'($signed(r.point));
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Test curve
   // ------------------------------------------------------------------
   function automatic logic signed [31:0] rnd32();
      return $urandom();
   endfunction

   function automatic void set_curve(longint lo, longint hi);
      cur_shape  = curve_type'($urandom_range(0, 4));
      cur_center = lo + ((hi - lo) * longint'($urandom_range(0, 1000))) / 1000;
      cur_offset = longint'($signed($urandom())) >>> $urandom_range(0, 31);
      cur_rising = 1'($urandom_range(0, 1));
   endfunction

   function automatic logic signed [31:0] sample_curve(longint x);
      longint d, v;
      case (cur_shape)
         CV_BOWL: begin
            d = (x - cur_center) >>> 12;
            v = d * d + cur_offset;
         end
         CV_VEE: begin
            d = x - cur_center;
            v = ((d < 0) ? -d : d) + cur_offset;
         end
         CV_FLAT:  v = cur_offset;
         CV_SLOPE: v = cur_rising ? x : -x;
         default:  v = longint'($signed($urandom()));
      endcase
      return 32'(clip_word(v));
   endfunction

   // ------------------------------------------------------------------
   // Sender, configuration and pauses
   // ------------------------------------------------------------------
   // Offer one transaction; hold it until accepted, then record what it should yield.
   task automatic send_item(input logic kind, input logic signed [31:0] lo,
                            input logic signed [31:0] hi, input logic signed [31:0] fv);
      int             gap;
      gss_result_type want;
      // pace the sender in bursts separated by random gaps
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_interval_low  <= lo;
      req_interval_high <= hi;
      req_func_value    <= fv;
      do @(posedge clock); while (!req_ready);
      want = predict_search(kind, lo, hi, fv);
      pending_results.push_back(want);
      sent_items++;
   endtask

   // Stop offering until every predicted result has drained, then wait a little more.
   task automatic drain(int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [gss_pkg::TOL_W-1:0] value);
      drain(SETTLE);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gs_tol = value;
   endtask

   // Answer evaluate requests until the search reports its minimum.
   task automatic finish_search(int noise_pct);
      while (gs_stage != ST_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(gss_pkg::KIND_START, rnd32(), rnd32(), rnd32());   // refused
         if ($urandom_range(0, 199) == 0)
            drain(0);
         send_item(gss_pkg::KIND_REPLY, rnd32(), rnd32(), sample_curve(gs_last_point));
      end
   endtask

   task automatic run_search(logic signed [31:0] lo, logic signed [31:0] hi, int noise_pct);
      set_curve(lo, hi);
      send_item(gss_pkg::KIND_START, lo, hi, rnd32());
      finish_search(noise_pct);
   endtask

   task automatic pick_interval(output logic signed [31:0] lo, output logic signed [31:0] hi);
      longint a, w;
      w = $urandom_range(0, 1 << 16);
      case ($urandom_range(0, 9))
         0, 1: begin
            a = longint'(rnd32());
            w = longint'(rnd32()) - a;
         end
         2: begin
            a = WORD_MIN + $urandom_range(0, 4096);
            w = $urandom_range(0, 1 << 20);
         end
         3: begin
            a = WORD_MAX - $urandom_range(0, 4096);
            w = -longint'($urandom_range(0, 1 << 20));
         end
         default: begin
            a = longint'(rnd32());
            if ($urandom_range(0, 1)) w = -w;
         end
      endcase
      lo = a[31:0];
      hi = 32'(clip_word(a + w));
   endtask

   function automatic logic [gss_pkg::TOL_W-1:0] pick_tolerance();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return 31'd1;
         2:       return 31'd66;
         3:       return gss_pkg::TOL_W'($urandom_range(2, 5000));
         4:       return gss_pkg::TOL_W'($urandom());
         5:       return 31'h7FFF_FFFF;
         default: return gss_pkg::TOL_W'($urandom_range(100, 1 << 20));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_reply_while_idle();
      send_item(gss_pkg::KIND_REPLY, rnd32(), rnd32(), 32'sh8000_0000);
   endtask

   // Width 5 is inside the reset tolerance: straight to the end points, then
   // equal values give the floored midpoint of a negative odd sum.
   task automatic test_narrow_interval();
      send_item(gss_pkg::KIND_START, -32'sd7, -32'sd2, '0);
      send_item(gss_pkg::KIND_REPLY, '0, '0, 32'sd5);
      send_item(gss_pkg::KIND_REPLY, '0, '0, 32'sd5);
   endtask

   task automatic test_full_range();
      write_tolerance(31'h7FFF_FFFF);
      send_item(gss_pkg::KIND_START, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      // busy: refused
      send_item(gss_pkg::KIND_START, 32'sh7FFF_FFFF, 32'sh8000_0000, '0);
      send_item(gss_pkg::KIND_REPLY, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_item(gss_pkg::KIND_REPLY, '0, '1, 32'sh8000_0000);
      cur_shape  = CV_FLAT;
      cur_offset = 0;
      finish_search(0);
   endtask

   task automatic test_reversed_interval();
      write_tolerance(31'h1000_0000);
      set_curve(-64'sd1073741824, 64'sd1073741824);
      cur_shape  = CV_BOWL;
      cur_center = 12345;
      send_item(gss_pkg::KIND_START, 32'sh4000_0000, 32'shC000_0000, '0);
      finish_search(0);
   endtask

   task automatic test_zero_tolerance();
      write_tolerance('0);
      set_curve(0, 4);
      cur_shape = CV_VEE;
      send_item(gss_pkg::KIND_START, 32'sd0, 32'sd4, '1);
      finish_search(0);
   endtask

   // Hold the receiver off while the sender keeps offering: the block fills
   // its result register and must stall req_ready.
   task automatic test_receiver_hold_off();
      hold_seq++;
      run_search(32'sd1000, 32'sd1000 + (1 << 14), 0);
   endtask

   // Pause the sender mid-search until every result is back, then resume.
   task automatic test_sender_pause();
      write_tolerance(31'd66);
      set_curve(-64'sd50000, 64'sd90000);
      send_item(gss_pkg::KIND_START, -32'sd50000, 32'sd90000, '0);
      repeat (3) if (gs_stage != ST_IDLE)
         send_item(gss_pkg::KIND_REPLY, '0, '0, sample_curve(gs_last_point));
      drain(0);
      finish_search(0);
   endtask

   task automatic test_random_searches();
      int                 searches;
      logic signed [31:0] lo, hi;
      searches = 0;
      while (sent_items < ITEMS_TARGET) begin
         if (searches % 6 == 0) write_tolerance(pick_tolerance());
         if ($urandom_range(0, 7) == 0)
            send_item(gss_pkg::KIND_REPLY, rnd32(), rnd32(), rnd32());   // reply while idle
         pick_interval(lo, hi);
         run_search(lo, hi, ($urandom_range(0, 3) == 0) ? 8 : 0);
         searches++;
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver: random ready patterns, plus a counted hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         beat = (beat + 1) % 5;
         case (rx_mode)
            RX_OPEN: rsp_ready <= 1'b1;
            RX_COIN: rsp_ready <= ($urandom_range(0, 1) == 0);
            RX_SLOW: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (beat < 3);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : check_results
      gss_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d point %0d",
                                      rsp_result_kind, rsp_point));
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind)
               report_mismatch($sformatf("result kind %0d, want %0d",
                                         rsp_result_kind, want.kind));
            if (rsp_point !== want.point)
               report_mismatch($sformatf("point %0d, want %0d (kind %0d)",
                                         rsp_point, $signed(want.point), want.kind));
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reply_while_idle();
      test_narrow_interval();
      test_full_range();
      test_reversed_interval();
      test_zero_tolerance();
      test_receiver_hold_off();
      test_sender_pause();
      test_random_searches();

      drain(SETTLE);
      if (mismatches == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
